FILE: hdl/video_bitrate_rate_controller_assert.svh
// assertion macros for the rate controller port checks
`ifndef VIDEO_BITRATE_RATE_CONTROLLER_ASSERT_SVH
`define VIDEO_BITRATE_RATE_CONTROLLER_ASSERT_SVH

// antecedent holds, consequent holds in the next cycle
`define VBRC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("port check failed");

// antecedent and consequent in the same cycle
`define VBRC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("port check failed");

`endif

FILE: hdl/vbrc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package vbrc_pkg;

	localparam int RATE_WIDTH_DEF = 16;
	localparam int TIME_WIDTH_DEF = 32;

	localparam int CFG_W     = 16;
	localparam int CFG_IDX_W = 2;
	localparam int FUNC_W    = 2;
	localparam int NOW_W     = 32;
	localparam int LOSS_W    = 16;
	localparam int RTT_W     = 32;
	localparam int IVL_W     = 32;
	localparam int OUT_W     = 16;

	localparam int NOW_LSB   = 0;
	localparam int LOSS_LSB  = NOW_LSB + NOW_W;
	localparam int RTT_LSB   = LOSS_LSB + LOSS_W;
	localparam int IVL_LSB   = RTT_LSB + RTT_W;
	localparam int IN_DATA_W = IVL_LSB + IVL_W;

	// divider: widest dividend is 9*avg+sample
	localparam int DIV_W   = 36;
	localparam int LEN_W   = 6;
	localparam int CUT_LEN = 24;

	localparam logic [CFG_W-1:0] MAX_RESET    = 16'd512;
	localparam logic [CFG_W-1:0] MIN_RESET    = 16'd50;
	localparam logic [CFG_W-1:0] NORMAL_RESET = 16'd100;

	localparam int CTRL_PERIOD_MS = 400;
	localparam int PROBE_SLOW_MS  = 30000;
	localparam int PROBE_FAST_MS  = 15000;
	localparam int PROBE_START_MS = 5000;
	localparam int CUT_NUMERATOR  = 11200000;
	localparam int LOSS_STEP      = 6;
	localparam int PROBE_ADD      = 10;
	localparam int DROP_DIV       = 20;
	localparam int PROBE_DIV      = 10;
	localparam int RTT_DIV        = 10;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_LOSS     = 2'd0,
		FUNC_RTT      = 2'd1,
		FUNC_INTERVAL = 2'd2,
		FUNC_RATE     = 2'd3
	} func_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX    = 2'd0,
		REG_MIN    = 2'd1,
		REG_NORMAL = 2'd2
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] max_rate;
		logic [CFG_W-1:0] min_rate;
		logic [CFG_W-1:0] normal_rate;
	} cfg_t;

	typedef struct packed {
		logic             start;
		logic [LEN_W-1:0] len;
	} div_req_t;

endpackage
`default_nettype wire

FILE: hdl/vbrc_serdiv.sv
`timescale 1ns / 1ps
`default_nettype none
module vbrc_serdiv (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire vbrc_pkg::div_req_t         req,
	input  wire logic [vbrc_pkg::DIV_W-1:0] dividend,
	input  wire logic [vbrc_pkg::IVL_W-1:0] divisor,
	output logic                            done,
	output logic [vbrc_pkg::DIV_W-1:0]      quotient
);

	localparam int DW = vbrc_pkg::DIV_W;
	localparam int VW = vbrc_pkg::IVL_W;

	logic                         busy_q;
	logic                         done_q;
	logic [vbrc_pkg::LEN_W-1:0]   cnt_q;
	logic [VW-1:0]                rem_q;
	logic [DW-1:0]                quo_q;
	logic [VW:0]                  rem_sh;
	logic [VW:0]                  rem_sub;
	logic                         fits;

	// one quotient bit per cycle, msb first
	always_comb begin
		rem_sh  = {rem_q, quo_q[DW-1]};
		fits    = rem_sh >= {1'b0, divisor};
		rem_sub = rem_sh - {1'b0, divisor};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			rem_q  <= '0;
			quo_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.len;
				rem_q  <= '0;
				quo_q  <= dividend;
			end else if (busy_q) begin
				rem_q <= fits ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
				quo_q <= {quo_q[DW-2:0], fits};
				cnt_q <= cnt_q - vbrc_pkg::LEN_W'(1);
				if (cnt_q == vbrc_pkg::LEN_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule
`default_nettype wire

FILE: hdl/vbrc_core.sv
`timescale 1ns / 1ps
`default_nettype none
module vbrc_core #(
	parameter int RATE_WIDTH = vbrc_pkg::RATE_WIDTH_DEF,
	parameter int TIME_WIDTH = vbrc_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire vbrc_pkg::cfg_t              cfg,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [vbrc_pkg::FUNC_W-1:0] in_func,
	input  wire logic [vbrc_pkg::NOW_W-1:0]  in_now,
	input  wire logic [vbrc_pkg::LOSS_W-1:0] in_loss,
	input  wire logic [vbrc_pkg::RTT_W-1:0]  in_rtt,
	input  wire logic [vbrc_pkg::IVL_W-1:0]  in_ivl,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output logic [vbrc_pkg::OUT_W-1:0]       res_rate
);

	localparam int RW     = RATE_WIDTH;
	localparam int TW     = TIME_WIDTH;
	localparam int BASE_W = (RATE_WIDTH > vbrc_pkg::CFG_W) ? RATE_WIDTH : vbrc_pkg::CFG_W;
	localparam int CW     = BASE_W + 1;
	localparam int RDW    = CW + 5;
	localparam int DW     = vbrc_pkg::DIV_W;
	localparam int LW     = vbrc_pkg::LEN_W;
	localparam int VW     = vbrc_pkg::IVL_W;
	localparam int LSW    = vbrc_pkg::LOSS_W + 1;

	typedef enum logic [1:0] {
		EV_IDLE  = 2'd0,
		EV_ARMED = 2'd1,
		EV_HELD  = 2'd2
	} ev_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_INIT,
		S_PER,
		S_CUT0,
		S_CUT1,
		S_DROP0,
		S_DROP1,
		S_PCHK,
		S_PUP1,
		S_HOLD,
		S_SCHK,
		S_SUP1,
		S_CLAMP,
		S_OUT,
		S_RTT_A,
		S_RTT_B,
		S_RTT_C,
		S_RTT_D,
		S_RTT_E
	} state_t;

	state_t                     state_q;
	logic [RW-1:0]              cur_rate_q;
	logic [TW-1:0]              period_start_q;
	logic [TW-1:0]              probe_time_q;
	logic [TW-1:0]              event_time_q;
	ev_t                        loss_ev_q;
	ev_t                        rtt_ev_q;
	logic                       start_mode_q;
	logic [vbrc_pkg::LOSS_W-1:0] last_loss_q;
	logic [vbrc_pkg::RTT_W-1:0] avg_rtt_q;
	logic [VW-1:0]              interval_q;
	logic [TW-1:0]              now_q;
	logic [vbrc_pkg::RTT_W-1:0] sample_q;
	logic [DW-1:0]              acc_q;
	logic [CW-1:0]              rate_q;
	logic                       slow_q;
	logic                       div_start_q;
	logic [LW-1:0]              div_len_q;
	logic [DW-1:0]              div_a_q;
	logic [VW-1:0]              div_b_q;

	vbrc_pkg::div_req_t         div_req;
	logic                       div_done;
	logic [DW-1:0]              div_quo;

	logic [CW-1:0]              rel_rate;
	logic [TW-1:0]              since_per;
	logic [TW-1:0]              since_probe;
	logic [TW-1:0]              since_ev;
	logic [TW-1:0]              probe_wait;
	logic [RDW-1:0]             rate17;
	logic [RDW-1:0]             rate11;
	logic [CW-1:0]              drop_val;
	logic [CW-1:0]              up_sum;
	logic [CW-1:0]              clamp_lo;
	logic [CW-1:0]              clamp_hi;
	logic [DW-1:0]              cut_dividend;
	logic [DW-1:0]              rtt_sum;
	logic                       loss_arm;

	always_comb begin
		rel_rate     = (cur_rate_q == '0) ? CW'(cfg.max_rate) : CW'(cur_rate_q);
		since_per    = now_q - period_start_q;
		since_probe  = now_q - probe_time_q;
		since_ev     = now_q - event_time_q;
		probe_wait   = slow_q ? TW'(vbrc_pkg::PROBE_SLOW_MS) : TW'(vbrc_pkg::PROBE_FAST_MS);
		rate17       = RDW'({rate_q, 4'b0}) + RDW'(rate_q);
		rate11       = RDW'({rate_q, 3'b0}) + RDW'({rate_q, 1'b0}) + RDW'(rate_q);
		drop_val     = (div_quo == '0) ? '0 : CW'(div_quo) - CW'(1);
		up_sum       = CW'(div_quo) + CW'(vbrc_pkg::PROBE_ADD);
		clamp_lo     = (rate_q < CW'(cfg.min_rate)) ? CW'(cfg.min_rate) : rate_q;
		clamp_hi     = (clamp_lo > CW'(cfg.max_rate)) ? CW'(cfg.max_rate) : clamp_lo;
		cut_dividend = DW'(vbrc_pkg::CUT_NUMERATOR) << (DW - vbrc_pkg::CUT_LEN);
		rtt_sum      = acc_q + DW'(sample_q);
		loss_arm     = (loss_ev_q == EV_IDLE) && (last_loss_q != '0) &&
			({1'b0, in_loss} > ({1'b0, last_loss_q} + LSW'(vbrc_pkg::LOSS_STEP)));
		div_req.start = div_start_q;
		div_req.len   = div_len_q;
	end

	vbrc_serdiv u_serdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cur_rate_q     <= RW'(vbrc_pkg::MAX_RESET);
			period_start_q <= '0;
			probe_time_q   <= '0;
			event_time_q   <= '0;
			loss_ev_q      <= EV_IDLE;
			rtt_ev_q       <= EV_IDLE;
			start_mode_q   <= 1'b1;
			last_loss_q    <= '0;
			avg_rtt_q      <= '0;
			interval_q     <= '0;
			now_q          <= '0;
			sample_q       <= '0;
			acc_q          <= '0;
			rate_q         <= '0;
			slow_q         <= 1'b0;
			div_start_q    <= 1'b0;
			div_len_q      <= '0;
			div_a_q        <= '0;
			div_b_q        <= '0;
		end else begin
			div_start_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						now_q <= TW'(in_now);
						unique case (vbrc_pkg::func_t'(in_func))
							vbrc_pkg::FUNC_LOSS: begin
								if (loss_arm) begin
									loss_ev_q <= EV_ARMED;
								end
								last_loss_q <= in_loss;
							end
							vbrc_pkg::FUNC_RTT: begin
								sample_q <= in_rtt;
								if (avg_rtt_q == '0) begin
									avg_rtt_q <= in_rtt;
								end else begin
									state_q <= S_RTT_A;
								end
							end
							vbrc_pkg::FUNC_INTERVAL: begin
								interval_q <= in_ivl;
							end
							vbrc_pkg::FUNC_RATE: begin
								state_q <= S_INIT;
							end
						endcase
					end
				end
				S_INIT: begin
					if (start_mode_q && (loss_ev_q != EV_IDLE || rtt_ev_q != EV_IDLE ||
						CW'(cur_rate_q) > CW'(cfg.normal_rate))) begin
						start_mode_q <= 1'b0;
					end
					rate_q <= rel_rate;
					slow_q <= rel_rate > CW'(cfg.normal_rate);
					if (period_start_q == '0) begin
						period_start_q <= now_q;
					end
					if (probe_time_q == '0) begin
						probe_time_q <= now_q;
					end
					state_q <= S_PER;
				end
				S_PER: begin
					if (since_per >= TW'(vbrc_pkg::CTRL_PERIOD_MS)) begin
						period_start_q <= now_q;
						state_q        <= S_CUT0;
					end else begin
						state_q <= S_HOLD;
					end
				end
				S_CUT0: begin
					if (interval_q != '0) begin
						div_start_q <= 1'b1;
						div_len_q   <= LW'(vbrc_pkg::CUT_LEN);
						div_a_q     <= cut_dividend;
						div_b_q     <= interval_q;
						state_q     <= S_CUT1;
					end else begin
						state_q <= S_DROP0;
					end
				end
				S_CUT1: begin
					if (div_done) begin
						if (div_quo < DW'(rate_q)) begin
							rate_q       <= CW'(div_quo);
							probe_time_q <= now_q;
						end
						state_q <= S_DROP0;
					end
				end
				S_DROP0: begin
					if (loss_ev_q == EV_ARMED || rtt_ev_q == EV_ARMED) begin
						div_start_q <= 1'b1;
						div_len_q   <= LW'(RDW);
						div_a_q     <= DW'(rate17) << (DW - RDW);
						div_b_q     <= VW'(vbrc_pkg::DROP_DIV);
						state_q     <= S_DROP1;
					end else begin
						state_q <= S_PCHK;
					end
				end
				S_DROP1: begin
					if (div_done) begin
						rate_q <= drop_val;
						if (loss_ev_q == EV_ARMED) begin
							loss_ev_q <= EV_HELD;
						end else begin
							rtt_ev_q <= EV_HELD;
						end
						event_time_q <= now_q;
						state_q      <= S_PCHK;
					end
				end
				S_PCHK: begin
					if (since_probe > probe_wait) begin
						div_start_q <= 1'b1;
						div_len_q   <= LW'(RDW);
						div_a_q     <= DW'(rate11) << (DW - RDW);
						div_b_q     <= VW'(vbrc_pkg::PROBE_DIV);
						state_q     <= S_PUP1;
					end else begin
						state_q <= S_HOLD;
					end
				end
				S_PUP1: begin
					if (div_done) begin
						probe_time_q <= now_q;
						rate_q       <= (up_sum > CW'(cfg.max_rate)) ? CW'(cfg.max_rate) : up_sum;
						state_q      <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (since_ev > TW'(vbrc_pkg::CTRL_PERIOD_MS)) begin
						if (loss_ev_q == EV_HELD) begin
							loss_ev_q <= EV_IDLE;
						end
						if (rtt_ev_q == EV_HELD) begin
							rtt_ev_q <= EV_IDLE;
						end
					end
					state_q <= S_SCHK;
				end
				S_SCHK: begin
					if (start_mode_q && since_probe > TW'(vbrc_pkg::PROBE_START_MS)) begin
						div_start_q <= 1'b1;
						div_len_q   <= LW'(RDW);
						div_a_q     <= DW'(rate11) << (DW - RDW);
						div_b_q     <= VW'(vbrc_pkg::PROBE_DIV);
						state_q     <= S_SUP1;
					end else begin
						state_q <= S_CLAMP;
					end
				end
				S_SUP1: begin
					if (div_done) begin
						probe_time_q <= now_q;
						rate_q       <= up_sum;
						state_q      <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					cur_rate_q <= RW'(clamp_hi);
					state_q    <= S_OUT;
				end
				S_OUT: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_RTT_A: begin
					acc_q   <= DW'({avg_rtt_q, 3'b0}) + DW'(avg_rtt_q);
					state_q <= S_RTT_B;
				end
				S_RTT_B: begin
					div_start_q <= 1'b1;
					div_len_q   <= LW'(DW);
					div_a_q     <= rtt_sum;
					div_b_q     <= VW'(vbrc_pkg::RTT_DIV);
					state_q     <= S_RTT_C;
				end
				S_RTT_C: begin
					if (div_done) begin
						avg_rtt_q <= vbrc_pkg::RTT_W'(div_quo);
						state_q   <= S_RTT_D;
					end
				end
				S_RTT_D: begin
					acc_q   <= DW'({avg_rtt_q, 3'b0}) + DW'({avg_rtt_q, 1'b0});
					state_q <= S_RTT_E;
				end
				S_RTT_E: begin
					if (rtt_ev_q == EV_IDLE && DW'(sample_q) > acc_q) begin
						rtt_ev_q <= EV_ARMED;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_OUT);
	assign res_rate  = vbrc_pkg::OUT_W'(cur_rate_q);

endmodule
`default_nettype wire

FILE: hdl/video_bitrate_rate_controller.sv
// loss and interval updates and a first rtt sample are handled in idle; a later rtt sample runs
// the averaging steps. A rate request runs the cut, the drop and the period probe only when a
// control period ends, each one pass of the bit-serial divider, one quotient bit per cycle (24
// bits for the cut, max(rate width, 16) + 6 for the rate steps); a start probe never joins a drop
// one word in work at a time; the result waits in the output register while the next word enters
// arst_n clears all state at once: rate = 512, registers 512/50/100, events idle, start mode on
`timescale 1ns / 1ps
`default_nettype none
module video_bitrate_rate_controller #(
	parameter int RATE_WIDTH = vbrc_pkg::RATE_WIDTH_DEF,
	parameter int TIME_WIDTH = vbrc_pkg::TIME_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_axis_tvalid,
	output logic                                   s_axis_tready,
	// now_ms[31:0], loss_fraction[47:32], rtt_sample_us[79:48], packet_interval[111:80]
	input  wire logic [vbrc_pkg::IN_DATA_W-1:0]    s_axis_tdata,
	// func[1:0]
	input  wire logic [vbrc_pkg::FUNC_W-1:0]       s_axis_tuser,
	output logic                                   m_axis_tvalid,
	input  wire logic                              m_axis_tready,
	// rate_kbps[15:0]
	output logic [vbrc_pkg::OUT_W-1:0]             m_axis_tdata,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [vbrc_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [vbrc_pkg::CFG_W-1:0]        cfg_data
);

	vbrc_pkg::cfg_t               cfg_q;
	logic                         m_valid_q;
	logic [vbrc_pkg::OUT_W-1:0]   m_data_q;
	logic                         res_valid;
	logic                         res_ready;
	logic [vbrc_pkg::OUT_W-1:0]   res_rate;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_rate    <= vbrc_pkg::MAX_RESET;
			cfg_q.min_rate    <= vbrc_pkg::MIN_RESET;
			cfg_q.normal_rate <= vbrc_pkg::NORMAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (vbrc_pkg::reg_idx_t'(cfg_index))
				vbrc_pkg::REG_MAX:    cfg_q.max_rate    <= cfg_data;
				vbrc_pkg::REG_MIN:    cfg_q.min_rate    <= cfg_data;
				vbrc_pkg::REG_NORMAL: cfg_q.normal_rate <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	vbrc_core #(
		.RATE_WIDTH (RATE_WIDTH),
		.TIME_WIDTH (TIME_WIDTH)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_func   (s_axis_tuser),
		.in_now    (s_axis_tdata[vbrc_pkg::NOW_LSB +: vbrc_pkg::NOW_W]),
		.in_loss   (s_axis_tdata[vbrc_pkg::LOSS_LSB +: vbrc_pkg::LOSS_W]),
		.in_rtt    (s_axis_tdata[vbrc_pkg::RTT_LSB +: vbrc_pkg::RTT_W]),
		.in_ivl    (s_axis_tdata[vbrc_pkg::IVL_LSB +: vbrc_pkg::IVL_W]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_rate  (res_rate)
	);

	// output register
	assign res_ready = !m_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			m_data_q  <= '0;
		end else if (res_valid && res_ready) begin
			m_valid_q <= 1'b1;
			m_data_q  <= res_rate;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign cfg_ready     = 1'b1;

endmodule
`default_nettype wire

FILE: hdl/vbrc_port_chk.sv
`timescale 1ns / 1ps
`default_nettype none
`include "video_bitrate_rate_controller_assert.svh"
module vbrc_port_chk (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           s_axis_tvalid,
	input wire logic                           s_axis_tready,
	input wire logic [vbrc_pkg::FUNC_W-1:0]    s_axis_tuser,
	input wire logic                           m_axis_tvalid,
	input wire logic                           m_axis_tready,
	input wire logic [vbrc_pkg::OUT_W-1:0]     m_axis_tdata,
	input wire logic                           cfg_valid,
	input wire logic                           cfg_ready
);

	logic in_word;
	logic upd_word;
	logic cfg_word;

	assign in_word  = s_axis_tvalid && s_axis_tready;
	assign upd_word = in_word && (s_axis_tuser == vbrc_pkg::FUNC_LOSS ||
		s_axis_tuser == vbrc_pkg::FUNC_INTERVAL);
	assign cfg_word = cfg_valid && cfg_ready;

	`VBRC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
	`VBRC_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
	`VBRC_ASSERT_NEXT(a_req_busy, in_word && s_axis_tuser == vbrc_pkg::FUNC_RATE, !s_axis_tready)
	`VBRC_ASSERT_NEXT(a_upd_fast, upd_word, s_axis_tready)
	`VBRC_ASSERT_SAME(a_cfg_taken, cfg_valid, cfg_word)

endmodule

bind video_bitrate_rate_controller vbrc_port_chk u_port_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.cfg_valid     (cfg_valid),
	.cfg_ready     (cfg_ready)
);
`default_nettype wire
